[sv/ptq_pkg.sv]
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants of the periodic timer queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

    localparam int DUE_W       = 28;
    localparam int PER_W       = 27;
    localparam int OWN_W       = 8;
    localparam int EVT_W       = 16;
    localparam int TIME_W      = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        PASS_SCAN   = 2'd0,
        PASS_REBASE = 2'd1,
        PASS_REMOVE = 2'd2
    } pass_t;

    typedef struct packed {
        logic [DUE_W-1:0] due;
        logic [PER_W-1:0] period;
        logic [OWN_W-1:0] owner;
        logic [EVT_W-1:0] evt;
    } timer_rec_t;

    typedef struct packed {
        logic  start_pass;
        pass_t pass_mode;
        logic  pass_run;
        logic  calc_time;
        logic  apply_time;
        logic  finish_rebase;
        logic  do_add;
        logic  fire;
        logic  flush;
        logic  clr_count;
    } ptq_cmd_t;

    typedef struct packed {
        logic pass_done;
        logic found;
        logic rebase_need;
        logic pending_vld;
        logic out_free;
        logic count_last;
    } ptq_status_t;

endpackage

[sv/ptq_ram.sv]
// ----------------------------------------------------------------------------
// ptq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptq_ram #(
    parameter int WIDTH = 79,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/ptq_datapath.sv]
// ----------------------------------------------------------------------------
// ptq_datapath
// Timer store, time base, slot passes, best-timer search and result register.
// ----------------------------------------------------------------------------
module ptq_datapath #(
    parameter int CAPACITY     = 32,
    parameter int REBASE_LIMIT = 86400000
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptq_pkg::ptq_cmd_t           cmd,
    output ptq_pkg::ptq_status_t        status,
    input  logic                        in_accept,
    input  logic [ptq_pkg::OWN_W-1:0]   in_owner,
    input  logic [ptq_pkg::EVT_W-1:0]   in_event,
    input  logic [ptq_pkg::PER_W-1:0]   in_period,
    input  logic [ptq_pkg::TIME_W-1:0]  in_now,
    input  logic [ptq_pkg::TIME_W-1:0]  start_offset,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ptq_pkg::OWN_W-1:0]   out_owner,
    output logic [ptq_pkg::EVT_W-1:0]   out_event,
    output logic                        out_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // request latch
    logic [ptq_pkg::OWN_W-1:0]  owner_reg;
    logic [ptq_pkg::EVT_W-1:0]  event_reg;
    logic [ptq_pkg::PER_W-1:0]  period_reg;
    logic [ptq_pkg::TIME_W-1:0] now_reg;

    logic [CAPACITY-1:0]        used_reg, used_next;
    logic [ptq_pkg::DUE_W-1:0]  cur_reg;
    logic [ptq_pkg::TIME_W-1:0] total_reg;
    logic [ptq_pkg::TIME_W-1:0] t_reg;

    ptq_pkg::pass_t             mode_reg;
    logic [CW-1:0]              idx_reg;
    logic                       chk_vld_reg;
    logic [AW-1:0]              chk_idx_reg;
    logic                       issue;

    logic                       found_reg;
    logic [AW-1:0]              best_idx_reg;
    ptq_pkg::timer_rec_t        best_rec_reg;

    logic                       pend_vld_reg;
    logic [ptq_pkg::OWN_W-1:0]  pend_owner_reg;
    logic [ptq_pkg::EVT_W-1:0]  pend_event_reg;
    logic [ptq_pkg::CNT_W-1:0]  count_reg;

    logic                       out_valid_reg;
    logic [ptq_pkg::OWN_W-1:0]  out_owner_reg;
    logic [ptq_pkg::EVT_W-1:0]  out_event_reg;
    logic                       out_last_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    ptq_pkg::timer_rec_t        ram_wdata;
    ptq_pkg::timer_rec_t        rd_rec;

    logic [AW-1:0]              free_idx;
    logic                       any_free;
    logic [ptq_pkg::PER_W-1:0]  per1;
    logic                       cand;
    logic                       out_free;
    logic                       push;

    ptq_ram #(
        .WIDTH ($bits(ptq_pkg::timer_rec_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_rec)
    );

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = AW'(i);
            end
        end
    end

    assign any_free = ~&used_reg;
    assign per1     = (period_reg == '0) ? ptq_pkg::PER_W'(1) : period_reg;
    assign issue    = cmd.pass_run && (idx_reg != CW'(CAPACITY));
    assign out_free = !out_valid_reg || out_ready;

    // scan candidate: due, earlier than best so far (ties keep lower slot)
    assign cand = chk_vld_reg && (mode_reg == ptq_pkg::PASS_SCAN) && used_reg[chk_idx_reg]
                  && (rd_rec.due <= cur_reg)
                  && (!found_reg || (rd_rec.due < best_rec_reg.due));

    // single RAM write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = rd_rec;
        if (cmd.do_add)
        begin
            ram_we           = any_free;
            ram_waddr        = free_idx;
            ram_wdata.due    = ptq_pkg::DUE_W'(cur_reg + ptq_pkg::DUE_W'(per1));
            ram_wdata.period = per1;
            ram_wdata.owner  = owner_reg;
            ram_wdata.evt    = event_reg;
        end
        else if (cmd.fire)
        begin
            ram_we        = 1'b1;
            ram_waddr     = best_idx_reg;
            ram_wdata     = best_rec_reg;
            ram_wdata.due = ptq_pkg::DUE_W'(cur_reg + ptq_pkg::DUE_W'(best_rec_reg.period));
        end
        else if (chk_vld_reg && (mode_reg == ptq_pkg::PASS_REBASE) && used_reg[chk_idx_reg])
        begin
            ram_we = 1'b1;
            if (ptq_pkg::TIME_W'(rd_rec.due) <= t_reg)
            begin
                ram_wdata.due = '0;
            end
            else
            begin
                ram_wdata.due = rd_rec.due - t_reg[ptq_pkg::DUE_W-1:0];
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.do_add && any_free)
        begin
            used_next[free_idx] = 1'b1;
        end
        if (chk_vld_reg && (mode_reg == ptq_pkg::PASS_REMOVE) && used_reg[chk_idx_reg]
            && (rd_rec.owner == owner_reg)
            && ((event_reg == '0) || (rd_rec.evt == event_reg)))
        begin
            used_next[chk_idx_reg] = 1'b0;
        end
    end

    assign push = (cmd.fire && pend_vld_reg) || cmd.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            cur_reg       <= '0;
            total_reg     <= '0;
            mode_reg      <= ptq_pkg::PASS_SCAN;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            pend_vld_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;

            if (cmd.apply_time)
            begin
                cur_reg <= t_reg[ptq_pkg::DUE_W-1:0];
            end
            else if (cmd.finish_rebase)
            begin
                cur_reg   <= '0;
                total_reg <= total_reg + t_reg;
            end

            if (cmd.start_pass)
            begin
                mode_reg    <= cmd.pass_mode;
                idx_reg     <= '0;
                chk_vld_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                chk_vld_reg <= issue;
                if (cand)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.fire)
            begin
                count_reg <= count_reg + ptq_pkg::CNT_W'(1);
            end

            if (cmd.fire)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_vld_reg <= 1'b0;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            owner_reg  <= in_owner;
            event_reg  <= in_event;
            period_reg <= in_period;
            now_reg    <= in_now;
        end
        if (cmd.calc_time)
        begin
            t_reg <= now_reg - start_offset - total_reg;
        end
        chk_idx_reg <= idx_reg[AW-1:0];
        if (cand)
        begin
            best_idx_reg <= chk_idx_reg;
            best_rec_reg <= rd_rec;
        end
        if (cmd.fire)
        begin
            pend_owner_reg <= best_rec_reg.owner;
            pend_event_reg <= best_rec_reg.evt;
        end
        if (push)
        begin
            out_owner_reg <= pend_owner_reg;
            out_event_reg <= pend_event_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign status.pass_done   = (idx_reg == CW'(CAPACITY)) && !chk_vld_reg;
    assign status.found       = found_reg;
    assign status.rebase_need = t_reg > ptq_pkg::TIME_W'(REBASE_LIMIT);
    assign status.pending_vld = pend_vld_reg;
    assign status.out_free    = out_free;
    assign status.count_last  = count_reg == ptq_pkg::CNT_W'(ptq_pkg::MAX_RESULTS - 1);

    assign out_valid = out_valid_reg;
    assign out_owner = out_owner_reg;
    assign out_event = out_event_reg;
    assign out_last  = out_last_reg;

endmodule

[sv/ptq_ctrl.sv]
// ----------------------------------------------------------------------------
// ptq_ctrl
// Request sequencer: add, remove pass, tick with rebase, scan and fire loop.
// ----------------------------------------------------------------------------
module ptq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_req,
    input  ptq_pkg::ptq_status_t status,
    output ptq_pkg::ptq_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_REMOVE,
        ST_TIME,
        ST_CHECK,
        ST_REBASE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   flushing_reg, flushing_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && !flushing_reg;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        flushing_next = flushing_reg;
        cmd           = '0;
        cmd.pass_mode = ptq_pkg::PASS_SCAN;

        // drain the held result of the tick as the last one
        if (flushing_reg)
        begin
            if (!status.pending_vld)
            begin
                flushing_next = 1'b0;
            end
            else if (status.out_free)
            begin
                cmd.flush     = 1'b1;
                flushing_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_req)
                        ptq_pkg::REQ_ADD:    state_next = ST_ADD;
                        ptq_pkg::REQ_REMOVE:
                        begin
                            cmd.start_pass = 1'b1;
                            cmd.pass_mode  = ptq_pkg::PASS_REMOVE;
                            state_next     = ST_REMOVE;
                        end
                        ptq_pkg::REQ_TICK:   state_next = ST_TIME;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:
            begin
                cmd.do_add = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REMOVE:
            begin
                cmd.pass_run = 1'b1;
                if (status.pass_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TIME:
            begin
                cmd.calc_time = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.start_pass = 1'b1;
                if (status.rebase_need)
                begin
                    cmd.pass_mode = ptq_pkg::PASS_REBASE;
                    state_next    = ST_REBASE;
                end
                else
                begin
                    cmd.apply_time = 1'b1;
                    cmd.clr_count  = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_REBASE:
            begin
                cmd.pass_run = 1'b1;
                if (status.pass_done)
                begin
                    cmd.pass_run      = 1'b0;
                    cmd.finish_rebase = 1'b1;
                    cmd.start_pass    = 1'b1;
                    cmd.clr_count     = 1'b1;
                    state_next        = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.pass_run = 1'b1;
                if (status.pass_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!status.found)
                begin
                    flushing_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (!status.pending_vld || status.out_free)
                begin
                    cmd.fire = 1'b1;
                    if (status.count_last)
                    begin
                        flushing_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.start_pass = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            flushing_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            flushing_reg <= flushing_next;
        end
    end

endmodule

[sv/periodic_timer_queue_top.sv]
// ----------------------------------------------------------------------------
// periodic_timer_queue_top
// Store of periodic timers with register, remove and tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, kind in tuser (add, remove, tick).
//   Every timer due on a tick leaves on m_axis as one item, earliest due time
//   first, ties by lower slot; tlast marks the last item of that tick.
//   start_offset is written through start_offset_we/wdata while idle.
// Passes:
//   remove: one pass over the slot RAM. tick: a rebase pass when needed,
//   then one search pass per fired timer and, unless 32 fired, one more
//   pass that finds nothing. Each fired timer costs a full search pass over
//   the single RAM read port, at most 32 per tick.
// Reset clears the slot valid bits, the time base and all handshake state;
//   timer contents need no clearing, no pass runs after reset.
// Stall: the output register holds one item and the search holds the next;
//   a stalled receiver holds the block in its tick, and s_axis_tready stays
//   low until the tick's last item has been handed to the output register.
// ----------------------------------------------------------------------------
module periodic_timer_queue_top #(
    parameter int CAPACITY     = 32,
    parameter int REBASE_LIMIT = 86400000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // owner_id[7:0], event_id[23:8],
                                        // period_ms[50:24], now_ms[82:51], pad
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // fired_owner[7:0], fired_event[23:8]
    output logic        m_axis_tlast,   // last_fired
    input  logic        start_offset_we,
    input  logic [31:0] start_offset_wdata
);

    ptq_pkg::ptq_cmd_t    cmd;
    ptq_pkg::ptq_status_t status;
    logic [31:0]          start_offset_reg;
    logic [7:0]           fired_owner;
    logic [15:0]          fired_event;

    // configuration register; the user writes it only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= '0;
        end
        else if (start_offset_we)
        begin
            start_offset_reg <= start_offset_wdata;
        end
    end

    ptq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (s_axis_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    ptq_datapath #(
        .CAPACITY     (CAPACITY),
        .REBASE_LIMIT (REBASE_LIMIT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_accept    (s_axis_tvalid && s_axis_tready),
        .in_owner     (s_axis_tdata[7:0]),
        .in_event     (s_axis_tdata[23:8]),
        .in_period    (s_axis_tdata[50:24]),
        .in_now       (s_axis_tdata[82:51]),
        .start_offset (start_offset_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_owner    (fired_owner),
        .out_event    (fired_event),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {fired_event, fired_owner};

endmodule

[sv/ptq_checker.sv]
// ----------------------------------------------------------------------------
// ptq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module ptq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [87:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // any real request leaves the block busy in the cycle after it is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != ptq_pkg::REQ_NONE)
        |=> !s_axis_tready)
        else $error("request taken without busy cycle");

    // add and remove produce no result right after they are taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
        && ((s_axis_tuser == ptq_pkg::REQ_ADD) || (s_axis_tuser == ptq_pkg::REQ_REMOVE))
        |=> !m_axis_tvalid)
        else $error("result without tick");

endmodule

bind periodic_timer_queue_top ptq_checker u_ptq_checker (.*);

[tb/ptq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptq_scoreboard
// Watches both item channels and the offset write port, keeps its own timer
// store, and compares every fired-timer item with the expected one.
// ----------------------------------------------------------------------------
module ptq_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        start_offset_we,
    input  logic [31:0] start_offset_wdata,
    output int          pending,
    output int          errors,
    output int          fired_total
);

    localparam int SLOTS = 32;
    localparam logic [31:0] DAY_MS = 32'd86400000;

    typedef struct packed {
        logic [ptq_pkg::OWN_W-1:0] owner;
        logic [ptq_pkg::EVT_W-1:0] evt;
        logic                      last;
    } fire_rec_t;

    fire_rec_t                 fire_q[$];
    logic [31:0]               offset_r;
    logic [ptq_pkg::DUE_W-1:0] due_r [SLOTS];
    logic [ptq_pkg::PER_W-1:0] per_r [SLOTS];
    logic [ptq_pkg::OWN_W-1:0] own_r [SLOTS];
    logic [ptq_pkg::EVT_W-1:0] evt_r [SLOTS];
    logic                      used_r[SLOTS];
    logic [ptq_pkg::DUE_W-1:0] now_r;
    logic [31:0]               shift_r;

    assign pending = fire_q.size();

    task automatic add_timer(logic [7:0] o, logic [15:0] e, logic [26:0] p);
        logic [26:0] pp;
        pp = (p == 0) ? 27'd1 : p;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!used_r[i])
            begin
                used_r[i] = 1'b1;
                own_r[i]  = o;
                evt_r[i]  = e;
                per_r[i]  = pp;
                due_r[i]  = now_r + ptq_pkg::DUE_W'(pp);
                return;
            end
        end
    endtask

    task automatic tick(logic [31:0] now);
        logic [31:0] t;
        logic        hit[SLOTS];
        int          n;
        int          best;
        fire_rec_t   rec;
        t = now - offset_r - shift_r;
        if (t <= DAY_MS)
            now_r = t[ptq_pkg::DUE_W-1:0];
        else
        begin
            // rebase: time base jumps forward by t
            for (int i = 0; i < SLOTS; i++)
                if (used_r[i])
                    due_r[i] = (32'(due_r[i]) <= t) ? '0
                               : ptq_pkg::DUE_W'(32'(due_r[i]) - t);
            shift_r = shift_r + t;
            now_r   = '0;
        end
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            hit[i] = 1'b0;
        while (n < ptq_pkg::MAX_RESULTS)
        begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
                if (used_r[i] && !hit[i] && due_r[i] <= now_r &&
                    (best < 0 || due_r[i] < due_r[best]))
                    best = i;
            if (best < 0)
                break;
            hit[best] = 1'b1;
            rec.owner = own_r[best];
            rec.evt   = evt_r[best];
            rec.last  = 1'b0;
            fire_q.insert(fire_q.size(), rec);
            n++;
        end
        if (n > 0)
            fire_q[fire_q.size()-1].last = 1'b1;
        for (int i = 0; i < SLOTS; i++)
            if (hit[i])
                due_r[i] = now_r + ptq_pkg::DUE_W'(per_r[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fire_rec_t   exp_r;
        logic [7:0]  o;
        logic [15:0] e;
        if (!rst_n)
        begin
            fire_q.delete();
            offset_r    = '0;
            now_r       = '0;
            shift_r     = '0;
            errors      = 0;
            fired_total = 0;
            for (int i = 0; i < SLOTS; i++)
                used_r[i] = 1'b0;
        end
        else
        begin
            // results first: one accepted this edge belongs to an older tick
            if (m_axis_tvalid && m_axis_tready)
            begin
                fired_total++;
                if (fire_q.size() == 0)
                begin
                    $error("unexpected item: owner %0d event %0d",
                           m_axis_tdata[7:0], m_axis_tdata[23:8]);
                    errors++;
                end
                else
                begin
                    exp_r = fire_q.pop_front();
                    if (m_axis_tdata[7:0] !== exp_r.owner)
                    begin
                        $error("fired_owner: expected %0d, got %0d",
                               exp_r.owner, m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[23:8] !== exp_r.evt)
                    begin
                        $error("fired_event: expected %0d, got %0d",
                               exp_r.evt, m_axis_tdata[23:8]);
                        errors++;
                    end
                    if (m_axis_tlast !== exp_r.last)
                    begin
                        $error("last_fired: expected %0d, got %0d",
                               exp_r.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (start_offset_we)
                offset_r = start_offset_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                o = s_axis_tdata[7:0];
                e = s_axis_tdata[23:8];
                case (s_axis_tuser)
                    ptq_pkg::REQ_ADD:
                        add_timer(o, e, s_axis_tdata[50:24]);
                    ptq_pkg::REQ_REMOVE:
                        for (int i = 0; i < SLOTS; i++)
                            if (used_r[i] && own_r[i] == o && (e == 0 || evt_r[i] == e))
                                used_r[i] = 1'b0;
                    ptq_pkg::REQ_TICK:
                        tick(s_axis_tdata[82:51]);
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives add, remove, tick and unknown items into the timer queue under four
// handshake mixes and four start offsets; the checker predicts the fired
// timers and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RAND_ITEMS = 200;
    localparam int WD_LIMIT   = 6000;   // idle cycles
    localparam int SETTLE     = 150;    // wait after drain, long enough for a remove pass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;     // owner_id, event_id, period_ms, now_ms, pad
    logic [1:0]  s_axis_tuser = '0;     // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // fired_owner, fired_event
    logic        m_axis_tlast;          // last_fired
    logic        start_offset_we = 1'b0;
    logic [31:0] start_offset_wdata = '0;

    int pending;
    int errors;
    int fired_total;
    int idle_pct  = 0;                  // sender gap chance, percent
    int stall_pct = 0;                  // receiver stall chance, percent
    int wd_count  = 0;
    int n_kind[4] = '{0, 0, 0, 0};
    logic [31:0] clk_ms = '0;           // running clock reading for ticks

    always #5 clk = ~clk;

    periodic_timer_queue_top uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tuser       (s_axis_tuser),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tlast       (m_axis_tlast),
        .start_offset_we    (start_offset_we),
        .start_offset_wdata (start_offset_wdata)
    );

    ptq_scoreboard chk (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tuser       (s_axis_tuser),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tlast       (m_axis_tlast),
        .start_offset_we    (start_offset_we),
        .start_offset_wdata (start_offset_wdata),
        .pending            (pending),
        .errors             (errors),
        .fired_total        (fired_total)
    );

    // receiver: random stalls at the current phase's rate
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // watchdog: any accepted item on either side restarts the count
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // one item; valid stays high into the next item unless a gap is drawn
    task automatic send_item(logic [1:0] kind, logic [7:0] own, logic [15:0] ev,
                             logic [26:0] per, logic [31:0] now);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, now, per, ev, own};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_kind[kind]++;
    endtask

    // offset writes only once the block has drained
    task automatic write_offset(logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        start_offset_we    <= 1'b1;
        start_offset_wdata <= v;
        @(posedge clk);
        start_offset_we    <= 1'b0;
        clk_ms = v + $urandom_range(0, 1000);
    endtask

    task automatic random_item();
        int          r;
        logic [7:0]  own;
        logic [15:0] ev;
        logic [26:0] per;
        r   = $urandom_range(99);
        // small owner/event pools so removes hit live timers
        own = ($urandom_range(9) < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        ev  = ($urandom_range(9) < 8) ? 16'($urandom_range(0, 5)) : 16'($urandom);
        if (r < 45)
        begin
            case ($urandom_range(9))
                0:       per = 27'($urandom_range(0, 86400000));
                1, 2:    per = 27'($urandom_range(0, 2000));
                default: per = 27'($urandom_range(0, 60));
            endcase
            send_item(ptq_pkg::REQ_ADD, own, ev, per, $urandom);
        end
        else if (r < 60)
        begin
            if ($urandom_range(9) < 4)
                ev = '0;
            send_item(ptq_pkg::REQ_REMOVE, own, ev, 27'($urandom), $urandom);
        end
        else if (r < 95)
        begin
            case ($urandom_range(19))
                0:       clk_ms = $urandom;                         // may step back
                1, 2:    clk_ms = clk_ms + $urandom_range(0, 90000000);
                default: clk_ms = clk_ms + $urandom_range(0, 40);
            endcase
            send_item(ptq_pkg::REQ_TICK, own, ev, 27'($urandom), clk_ms);
        end
        else
            send_item(ptq_pkg::REQ_NONE, own, ev, 27'($urandom), $urandom);
    endtask

    initial
    begin
        int pct_idle[4];
        int pct_stall[4];
        logic [31:0] offs[4];
        pct_idle  = '{0, 47, 0, 21};
        pct_stall = '{0, 0, 47, 21};
        offs      = '{32'hFFFF_FFFF, 32'd1000, 32'h8000_0000, 32'd0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, each request kind and the corner cases
        write_offset(32'd0);
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'd0); // nothing due
        send_item(ptq_pkg::REQ_ADD,    8'd255, 16'hFFFF, 27'd0,        32'hFFFF_FFFF); // zero period
        send_item(ptq_pkg::REQ_ADD,    8'd0,   16'd0,    27'd86400000, 32'd0);
        send_item(ptq_pkg::REQ_ADD,    8'd1,   16'd7,    27'd3,        32'd0);
        send_item(ptq_pkg::REQ_ADD,    8'd1,   16'd8,    27'd3,        32'd0);
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'd1); // one fires
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'd5); // tie by slot
        send_item(ptq_pkg::REQ_REMOVE, 8'd1,   16'd7,    27'd0,        32'd0); // one event
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'd9);
        send_item(ptq_pkg::REQ_REMOVE, 8'd1,   16'd0,    27'd0,        32'd0); // all of owner
        send_item(ptq_pkg::REQ_NONE,   8'd255, 16'hFFFF, 27'h7FF_FFFF, 32'hFFFF_FFFF); // unknown
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'd86400000); // at limit
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'd86400001); // rebase
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'd86400005);
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'd100); // clock back
        send_item(ptq_pkg::REQ_ADD,    8'd9,   16'd1,    27'd100,      32'd0);
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'hFFFF_FFFF);
        send_item(ptq_pkg::REQ_REMOVE, 8'd255, 16'hFFFF, 27'd0,        32'd0);
        send_item(ptq_pkg::REQ_TICK,   8'd0,   16'd0,    27'd0,        32'hFFFF_FFFF);
        // store full: 33 adds, those past the last free slot dropped, then all fire together
        for (int i = 0; i < 33; i++)
            send_item(ptq_pkg::REQ_ADD, 8'(i), 16'(i + 100), 27'($urandom_range(1, 4)),
                      32'd0);
        send_item(ptq_pkg::REQ_TICK, 8'd0, 16'd0, 27'd0, 32'h7000_0000);
        send_item(ptq_pkg::REQ_TICK, 8'd0, 16'd0, 27'd0, 32'h7000_0010);
        for (int i = 0; i < 8; i++)
            send_item(ptq_pkg::REQ_REMOVE, 8'(i * 4), 16'd0, 27'd0, 32'd0);

        // random phases, each with its own offset and handshake mix
        for (int ph = 0; ph < 4; ph++)
        begin
            write_offset(ph == 2 ? $urandom : offs[ph]);
            idle_pct  = pct_idle[ph];
            stall_pct = pct_stall[ph];
            for (int k = 0; k < RAND_ITEMS / 4; k++)
                random_item();
        end

        s_axis_tvalid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d adds, %0d removes, %0d ticks, %0d unknown items",
                 n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
        $display("%0d fired timers checked over four offsets and four handshake mixes",
                 fired_total);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
